// ===== rtl/core/ptq_pkg.sv =====
// types and constants shared by the periodic timer queue modules
package ptq_pkg;

	localparam int ID_W     = 4;
	localparam int PERIOD_W = 32;
	localparam int OP_W     = 2;
	localparam int IN_W     = 40;
	localparam int OUT_W    = 8;

	localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

	typedef enum logic [1:0] {
		ST_OK,
		ST_FULL,
		ST_ACTIVE,
		ST_NOT_ACTIVE
	} status_t;

	typedef struct packed {
		status_t           status;
		logic              fired;
		logic [ID_W-1:0]   fired_timer;
		logic              last;
	} res_t;

endpackage

// ===== rtl/core/ptq_ram.sv =====
// generic single write, single read ram with registered read data
module ptq_ram #(
	parameter int WIDTH = 84,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/core/ptq_seq.sv =====
// sequencer walking the sorted timer list held in the ram
module ptq_seq
	import ptq_pkg::*;
#(
	parameter int TIMER_SLOTS = 16,
	parameter int TIME_WIDTH  = 48
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic [OP_W-1:0]                          in_op,
	input  logic [ID_W-1:0]                          in_id,
	input  logic [PERIOD_W-1:0]                      in_per,
	output logic                                     res_valid,
	input  logic                                     res_ready,
	output res_t                                     res,
	output logic                                     wr_en,
	output logic [$clog2(TIMER_SLOTS)-1:0]           wr_addr,
	output logic [TIME_WIDTH+PERIOD_W+ID_W-1:0]      wr_data,
	output logic                                     rd_en,
	output logic [$clog2(TIMER_SLOTS)-1:0]           rd_addr,
	input  logic [TIME_WIDTH+PERIOD_W+ID_W-1:0]      rd_data
);

	localparam int AW = $clog2(TIMER_SLOTS);
	localparam int CW = $clog2(TIMER_SLOTS + 1);
	localparam int TW = TIME_WIDTH;
	localparam int EW = TW + PERIOD_W + ID_W;
	localparam int NID = 1 << ID_W;

	typedef enum logic [3:0] {
		S_IDLE, S_ADD_RD, S_ADD_EV, S_REM_RD, S_REM_EV,
		S_TK_RD0, S_TK_EV0, S_TK_RD, S_TK_EV, S_TK_END, S_RESP
	} state_t;

	function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a,
		input logic [PERIOD_W-1:0] b);
		logic [TW:0] s;
		s = {1'b0, a} + {{(TW + 1 - PERIOD_W){1'b0}}, b};
		return s[TW] ? {TW{1'b1}} : s[TW-1:0];
	endfunction

	state_t               state_q;
	logic [TW-1:0]        time_q;
	logic [TW-1:0]        dl_q;
	logic [PERIOD_W-1:0]  per_q;
	logic [ID_W-1:0]      id_q;
	logic [CW-1:0]        k_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        budget_q;
	logic                 found_q;
	logic [NID-1:0]       active_q;
	logic                 pend_v_q;
	logic [ID_W-1:0]      pend_id_q;
	status_t              stat_q;

	logic [TW-1:0]        rd_dl;
	logic [PERIOD_W-1:0]  rd_per;
	logic [ID_W-1:0]      rd_tid;
	logic [CW-1:0]        km1;
	logic [EW-1:0]        new_entry;
	logic                 expired;
	logic                 mv_cond;
	logic                 fire_ok;
	logic [PERIOD_W-1:0]  per_fix;

	assign rd_dl     = rd_data[EW-1 -: TW];
	assign rd_per    = rd_data[PERIOD_W+ID_W-1 -: PERIOD_W];
	assign rd_tid    = rd_data[ID_W-1:0];
	assign km1       = k_q - CW'(1);
	assign new_entry = {dl_q, per_q, id_q};
	assign expired   = rd_dl <= time_q;
	// first step keeps the timer in front on an equal deadline
	assign mv_cond   = (k_q == CW'(1)) ? (rd_dl < dl_q) : (rd_dl <= dl_q);
	assign fire_ok   = !pend_v_q || res_ready;
	assign per_fix   = (in_per == '0) ? PERIOD_W'(1) : in_per;
	assign in_ready  = state_q == S_IDLE;

	always_comb begin
		rd_en     = 1'b0;
		rd_addr   = '0;
		wr_en     = 1'b0;
		wr_addr   = '0;
		wr_data   = new_entry;
		res_valid = 1'b0;
		res       = '{status: ST_OK, fired: 1'b0, fired_timer: '0, last: 1'b1};
		case (state_q)
			S_ADD_RD: begin
				if (k_q != '0) begin
					rd_en   = 1'b1;
					rd_addr = km1[AW-1:0];
				end else begin
					wr_en = 1'b1;
				end
			end
			S_ADD_EV: begin
				wr_en   = 1'b1;
				wr_addr = k_q[AW-1:0];
				if (rd_dl > dl_q) begin
					wr_data = rd_data;
				end
			end
			S_REM_RD: begin
				if (k_q != count_q) begin
					rd_en   = 1'b1;
					rd_addr = k_q[AW-1:0];
				end
			end
			S_REM_EV: begin
				wr_en   = found_q;
				wr_addr = km1[AW-1:0];
				wr_data = rd_data;
			end
			S_TK_RD0: begin
				rd_en = budget_q != '0;
			end
			S_TK_EV0: begin
				res_valid = expired && pend_v_q;
				res       = '{status: ST_OK, fired: 1'b1, fired_timer: pend_id_q, last: 1'b0};
			end
			S_TK_RD: begin
				if (k_q == count_q) begin
					wr_en   = 1'b1;
					wr_addr = km1[AW-1:0];
				end else begin
					rd_en   = 1'b1;
					rd_addr = k_q[AW-1:0];
				end
			end
			S_TK_EV: begin
				wr_en   = 1'b1;
				wr_addr = km1[AW-1:0];
				if (mv_cond) begin
					wr_data = rd_data;
				end
			end
			S_TK_END: begin
				res_valid = pend_v_q;
				res       = '{status: ST_OK, fired: 1'b1, fired_timer: pend_id_q, last: 1'b1};
			end
			S_RESP: begin
				res_valid  = 1'b1;
				res.status = stat_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			time_q    <= '0;
			count_q   <= '0;
			active_q  <= '0;
			pend_v_q  <= 1'b0;
			k_q       <= '0;
			budget_q  <= '0;
			found_q   <= 1'b0;
			stat_q    <= ST_OK;
			dl_q      <= '0;
			per_q     <= '0;
			id_q      <= '0;
			pend_id_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						id_q <= in_id;
						case (in_op)
							OP_ADD: begin
								if (active_q[in_id]) begin
									stat_q  <= ST_ACTIVE;
									state_q <= S_RESP;
								end else if (count_q == CW'(TIMER_SLOTS)) begin
									stat_q  <= ST_FULL;
									state_q <= S_RESP;
								end else begin
									dl_q    <= sat_add(time_q, per_fix);
									per_q   <= per_fix;
									k_q     <= count_q;
									state_q <= S_ADD_RD;
								end
							end
							OP_REMOVE: begin
								if (!active_q[in_id]) begin
									stat_q  <= ST_NOT_ACTIVE;
									state_q <= S_RESP;
								end else begin
									k_q     <= '0;
									found_q <= 1'b0;
									state_q <= S_REM_RD;
								end
							end
							OP_TICK: begin
								time_q   <= sat_add(time_q, PERIOD_W'(1));
								budget_q <= count_q;
								state_q  <= S_TK_RD0;
							end
							default: begin
							end
						endcase
					end
				end
				S_ADD_RD: begin
					if (k_q != '0) begin
						state_q <= S_ADD_EV;
					end else begin
						active_q[id_q] <= 1'b1;
						count_q        <= count_q + CW'(1);
						stat_q         <= ST_OK;
						state_q        <= S_RESP;
					end
				end
				S_ADD_EV: begin
					if (rd_dl > dl_q) begin
						k_q     <= km1;
						state_q <= S_ADD_RD;
					end else begin
						active_q[id_q] <= 1'b1;
						count_q        <= count_q + CW'(1);
						stat_q         <= ST_OK;
						state_q        <= S_RESP;
					end
				end
				S_REM_RD: begin
					if (k_q == count_q) begin
						active_q[id_q] <= 1'b0;
						count_q        <= count_q - CW'(1);
						stat_q         <= ST_OK;
						state_q        <= S_RESP;
					end else begin
						state_q <= S_REM_EV;
					end
				end
				S_REM_EV: begin
					if (!found_q && rd_tid == id_q) begin
						found_q <= 1'b1;
					end
					k_q     <= k_q + CW'(1);
					state_q <= S_REM_RD;
				end
				S_TK_RD0: begin
					state_q <= (budget_q != '0) ? S_TK_EV0 : S_TK_END;
				end
				S_TK_EV0: begin
					if (!expired) begin
						state_q <= S_TK_END;
					end else if (fire_ok) begin
						// hold this firing back until we know whether another follows
						pend_v_q  <= 1'b1;
						pend_id_q <= rd_tid;
						dl_q      <= sat_add(rd_dl, rd_per);
						per_q     <= rd_per;
						id_q      <= rd_tid;
						budget_q  <= budget_q - CW'(1);
						k_q       <= CW'(1);
						state_q   <= S_TK_RD;
					end
				end
				S_TK_RD: begin
					state_q <= (k_q == count_q) ? S_TK_RD0 : S_TK_EV;
				end
				S_TK_EV: begin
					if (mv_cond) begin
						k_q     <= k_q + CW'(1);
						state_q <= S_TK_RD;
					end else begin
						state_q <= S_TK_RD0;
					end
				end
				S_TK_END: begin
					if (fire_ok) begin
						pend_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				S_RESP: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/periodic_timer_queue.sv =====
// periodic timer queue: list of timers sorted by deadline, kept in one ram
// add: entries with a later deadline are moved back one slot each, then the new timer is written
// remove: every stored entry is read and those behind the removed timer move forward one slot; tick: the front
// timer is checked, and each fired timer is rescheduled and moved back through the list to its new place
// one request is worked at a time; results leave through an output register, stalls add cycles
// reset clears time, entry count, active map and handshakes; list ram is not cleared
module periodic_timer_queue
	import ptq_pkg::*;
#(
	parameter int TIMER_SLOTS = 16,
	parameter int TIME_WIDTH  = 48
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // timer_id[3:0], period[35:4]
	input  logic [OP_W-1:0]  s_tuser,   // opcode[1:0]
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // status[1:0], fired_timer[5:2]
	output logic             m_tuser,   // fired[0]
	output logic             m_tlast
);

	localparam int AW = $clog2(TIMER_SLOTS);
	localparam int EW = TIME_WIDTH + PERIOD_W + ID_W;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [EW-1:0] wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [EW-1:0] rd_data;
	logic          res_valid;
	logic          res_ready;
	res_t          res;
	logic          m_tvalid_q;
	res_t          out_q;

	ptq_ram #(.WIDTH(EW), .DEPTH(TIMER_SLOTS)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	ptq_seq #(.TIMER_SLOTS(TIMER_SLOTS), .TIME_WIDTH(TIME_WIDTH)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (s_tuser),
		.in_id     (s_tdata[3:0]),
		.in_per    (s_tdata[35:4]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data)
	);

	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, out_q.fired_timer, out_q.status};
	assign m_tuser  = out_q.fired;
	assign m_tlast  = out_q.last;

`ifndef ASSERT_OFF
	a_idle_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !res_valid)
		else $error("result offered while taking a new request");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |=> m_tvalid)
		else $error("accepted result not presented");

	a_fired_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.fired |-> res.status == ST_OK)
		else $error("fired result with non-ok status");
`endif

endmodule

// ===== tb/periodic_timer_queue_test.sv =====
// self-checking testbench for the periodic timer queue: predicts every result and compares
`timescale 1ns / 100ps

module periodic_timer_queue_test;
	import ptq_pkg::*;

	localparam int SLOTS     = 16;
	localparam int TW        = 48;
	localparam int IDLE_MAX  = 6000;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam logic [TW-1:0] TIME_TOP = {TW{1'b1}};

	typedef struct {
		status_t         status;
		logic            fired;
		logic [ID_W-1:0] timer;
		logic            last;
	} outcome_t;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic [OP_W-1:0]  s_tuser;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic             m_tuser;
	logic             m_tlast;

	// predictor state
	logic [TW-1:0]       now_ticks;
	logic [TW-1:0]       q_deadline [SLOTS];
	logic [PERIOD_W-1:0] q_period [SLOTS];
	logic [ID_W-1:0]     q_timer [SLOTS];
	int                  q_count;
	bit [15:0]           is_active;

	outcome_t pending_results [$];
	int       mismatches;
	int       idle_cycles;
	int       hold_cycles;
	bit       no_gaps;
	int       stall_left;

	periodic_timer_queue i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	function automatic logic [TW-1:0] add_sat(logic [TW-1:0] a, logic [PERIOD_W-1:0] b);
		logic [TW:0] s;
		s = {1'b0, a} + {{(TW + 1 - PERIOD_W){1'b0}}, b};
		return s[TW] ? TIME_TOP : s[TW-1:0];
	endfunction

	function automatic void list_put(logic [TW-1:0] dl, logic [PERIOD_W-1:0] p,
			logic [ID_W-1:0] t);
		int pos;
		pos = 0;
		while (pos < q_count && q_deadline[pos] <= dl)
			pos++;
		for (int k = q_count; k > pos; k--) begin
			q_deadline[k] = q_deadline[k-1];
			q_period[k]   = q_period[k-1];
			q_timer[k]    = q_timer[k-1];
		end
		q_deadline[pos] = dl;
		q_period[pos]   = p;
		q_timer[pos]    = t;
		q_count++;
	endfunction

	function automatic void list_drop(int pos);
		for (int k = pos; k + 1 < q_count; k++) begin
			q_deadline[k] = q_deadline[k+1];
			q_period[k]   = q_period[k+1];
			q_timer[k]    = q_timer[k+1];
		end
		q_count--;
	endfunction

	function automatic void push_outcome(status_t st, logic f, logic [ID_W-1:0] t, logic l);
		outcome_t o;
		o.status = st;
		o.fired  = f;
		o.timer  = t;
		o.last   = l;
		pending_results.push_back(o);
	endfunction

	// works out the results of one accepted request
	function automatic void predict_timer_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
			logic [PERIOD_W-1:0] per);
		int budget;
		int n;
		logic [TW-1:0] dl;
		logic [PERIOD_W-1:0] p;
		logic [ID_W-1:0] t;
		if (op == OP_ADD) begin
			if (is_active[id]) begin
				push_outcome(ST_ACTIVE, 1'b0, '0, 1'b1);
			end else if (q_count >= SLOTS) begin
				push_outcome(ST_FULL, 1'b0, '0, 1'b1);
			end else begin
				if (per == 0)
					per = 1;
				list_put(add_sat(now_ticks, per), per, id);
				is_active[id] = 1'b1;
				push_outcome(ST_OK, 1'b0, '0, 1'b1);
			end
		end else if (op == OP_REMOVE) begin
			if (is_active[id]) begin
				for (int k = 0; k < q_count; k++) begin
					if (q_timer[k] == id) begin
						list_drop(k);
						break;
					end
				end
				is_active[id] = 1'b0;
				push_outcome(ST_OK, 1'b0, '0, 1'b1);
			end else begin
				push_outcome(ST_NOT_ACTIVE, 1'b0, '0, 1'b1);
			end
		end else if (op == OP_TICK) begin
			budget = q_count;
			n = 0;
			now_ticks = add_sat(now_ticks, 1);
			while (budget > 0 && q_count > 0 && q_deadline[0] <= now_ticks) begin
				budget--;
				push_outcome(ST_OK, 1'b1, q_timer[0], 1'b0);
				n++;
				q_deadline[0] = add_sat(q_deadline[0], q_period[0]);
				if (q_count > 1 && q_deadline[1] < q_deadline[0]) begin
					dl = q_deadline[0];
					p  = q_period[0];
					t  = q_timer[0];
					list_drop(0);
					list_put(dl, p, t);
				end
			end
			if (n > 0)
				pending_results[$].last = 1'b1;
		end
	endfunction

	task automatic send_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
			logic [PERIOD_W-1:0] per);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {4'b0000, per, id};
		do
			@(posedge clk);
		while (!s_tready);
		predict_timer_request(op, id, per);
		if (no_gaps)
			gap = 0;
		else if ($urandom_range(0, 19) == 0)
			gap = $urandom_range(8, 40);
		else if ($urandom_range(0, 1) == 0)
			gap = $urandom_range(1, 3);
		else
			gap = 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [PERIOD_W-1:0] pick_period();
		int r;
		r = $urandom_range(0, 19);
		if (r < 15)
			return $urandom_range(1, 6);
		else if (r < 17)
			return '0;
		else
			return $urandom;
	endfunction

	task automatic test_status_codes();
		send_request(OP_ADD, 4'd0, 32'd0);        // zero period counts as one
		send_request(OP_ADD, 4'd15, 32'hFFFF_FFFF);
		send_request(OP_ADD, 4'd0, 32'd3);        // already active
		send_request(OP_REMOVE, 4'd7, 32'd0);     // not active
		send_request(OP_TICK, 4'd0, 32'd0);
		send_request(OP_TICK, 4'd0, 32'd0);
		send_request(OP_REMOVE, 4'd15, 32'hAAAA_5555);
		send_request(OP_REMOVE, 4'd0, 32'h5555_AAAA);
		send_request(OP_TICK, 4'd9, 32'd5);       // nothing expires
		send_request(OP_UNUSED, 4'd3, 32'd2);     // ignored
		wait_drained();
	endtask

	task automatic test_full_table();
		no_gaps = 1'b1;
		for (int i = 0; i < SLOTS; i++)
			send_request(OP_ADD, ID_W'(i), 32'd1);
		no_gaps = 1'b0;
		send_request(OP_ADD, 4'd5, 32'd1);        // already active wins over full
		// every timer expires at once: sixteen results from one tick
		send_request(OP_TICK, 4'd0, 32'd0);
		send_request(OP_TICK, 4'd0, 32'd0);
		wait_drained();
		for (int i = 0; i < SLOTS; i++)
			send_request(OP_REMOVE, ID_W'(i), 32'd0);
		wait_drained();
	endtask

	task automatic test_backpressure();
		hold_cycles = 400;
		for (int i = 0; i < 12; i++)
			send_request(i % 3 == 2 ? OP_TICK : OP_ADD, ID_W'(i), 32'd2);
		wait_drained();
	endtask

	task automatic test_random_traffic();
		int r;
		for (int i = 0; i < 150; i++) begin
			if (i == 60)
				no_gaps = 1'b1;
			if (i == 90)
				no_gaps = 1'b0;
			r = $urandom_range(0, 99);
			if (r < 35)
				send_request(OP_ADD, ID_W'($urandom_range(0, 15)), pick_period());
			else if (r < 55)
				send_request(OP_REMOVE, ID_W'($urandom_range(0, 15)), $urandom);
			else if (r < 96)
				send_request(OP_TICK, ID_W'($urandom_range(0, 15)), $urandom);
			else
				send_request(OP_UNUSED, ID_W'($urandom_range(0, 15)), $urandom);
		end
		wait_drained();
	endtask

	// result side: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (no_gaps || $urandom_range(0, 9) < 7) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= 1'b0;
			stall_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
				: $urandom_range(0, 2);
		end
	end

	always @(posedge clk) begin
		outcome_t want;
		logic [1:0] got_status;
		if (arst_n && m_tvalid && m_tready) begin
			got_status = m_tdata[1:0];
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: tdata %h tuser %b tlast %b",
						m_tdata, m_tuser, m_tlast);
			end else begin
				want = pending_results.pop_front();
				if (got_status !== want.status || m_tuser !== want.fired
						|| m_tdata[5:2] !== want.timer || m_tlast !== want.last
						|| m_tdata[7:6] !== 2'b00) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected status %0d fired %b timer %0d last %b",
							want.status, want.fired, want.timer, want.last,
							", got status %0d fired %b timer %0d last %b",
							got_status, m_tuser, m_tdata[5:2], m_tlast);
				end
			end
		end
	end

	// stops a hung run
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_MAX) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		m_tready <= 1'b0;
		hold_cycles = 0;
		stall_left = 0;
		no_gaps = 1'b0;
		idle_cycles = 0;
		mismatches = 0;
		now_ticks = '0;
		q_count = 0;
		is_active = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_status_codes();
		test_full_table();
		test_backpressure();
		test_random_traffic();
		repeat (60) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/ptq_pkg.sv
rtl/core/ptq_ram.sv
rtl/core/ptq_seq.sv
rtl/core/periodic_timer_queue.sv
tb/periodic_timer_queue_test.sv
